/* rtl/mcodp_pkg.sv */
// Shared types and constants for the matrix chain order block.
// Holds the sequencer states, status codes and the control word that the
// sequencer hands to the arithmetic unit. No dependencies.
package mcodp_pkg;

	localparam int DIM_IN_BITS  = 12;
	localparam int COST_OUT_BITS = 48;
	localparam int IDX_OUT_BITS = 6;
	localparam int STATUS_BITS  = 2;

	localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_OVF   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_SHORT = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_SAT   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL,
		ST_CELL_A,
		ST_CELL_B,
		ST_K_RD,
		ST_K_MUL,
		ST_K_ACC,
		ST_WR,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic dim_we;
		logic dim_re;
		logic ld_a;
		logic ld_pij;
		logic cost_re;
		logic mul_en;
		logic acc_en;
		logic first_k;
		logic cost_we;
	} step_ctl_t;

endpackage

/* rtl/mcodp_unit.sv */
// Arithmetic unit of the matrix chain order block: dimension store, cost
// table memory, one shared multiplier and one shared saturating adder.
// Depends on mcodp_pkg for the control word.
module mcodp_unit #(
	parameter int MAX_DIMS  = 8,
	parameter int DIM_BITS  = 12,
	parameter int COST_BITS = 48,
	parameter int IDX_BITS  = $clog2(MAX_DIMS)
) (
	input  logic                   clk,
	input  mcodp_pkg::step_ctl_t   ctl,
	input  logic [IDX_BITS-1:0]    dim_addr,
	input  logic [DIM_BITS-1:0]    dim_wdata,
	input  logic [IDX_BITS-1:0]    idx_i,
	input  logic [IDX_BITS-1:0]    idx_j,
	input  logic [IDX_BITS-1:0]    idx_k,
	output logic [COST_BITS-1:0]   best_cost,
	output logic [IDX_BITS-1:0]    best_split
);
	import mcodp_pkg::*;

	localparam int PIJ_BITS   = 2 * DIM_BITS;
	localparam int PROD_BITS  = 3 * DIM_BITS;
	localparam int SAT_BITS   = (PROD_BITS > COST_BITS) ? PROD_BITS : COST_BITS;
	localparam int COST_DEPTH = 1 << (2 * IDX_BITS);

	logic [DIM_BITS-1:0]  dim_mem [MAX_DIMS];
	logic [COST_BITS-1:0] cost_mem [COST_DEPTH];

	logic [DIM_BITS-1:0]  dim_rd_q;
	logic [DIM_BITS-1:0]  a_q;
	logic [PIJ_BITS-1:0]  pij_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [COST_BITS-1:0] cl_q;
	logic [COST_BITS-1:0] cr_q;
	logic                 zl_q;
	logic                 zr_q;
	logic [COST_BITS-1:0] lr_q;
	logic [COST_BITS-1:0] best_q;
	logic [IDX_BITS-1:0]  bestk_q;

	logic [IDX_BITS-1:0]   kp1;
	logic [PIJ_BITS-1:0]   mul_op;
	logic [PROD_BITS-1:0]  mul_out;
	logic [SAT_BITS-1:0]   prod_w;
	logic [SAT_BITS-1:0]   cmax_w;
	logic [COST_BITS-1:0]  psat;
	logic [COST_BITS-1:0]  add_a;
	logic [COST_BITS-1:0]  add_b;
	logic [COST_BITS:0]    sum_w;
	logic [COST_BITS-1:0]  add_sat;
	logic                  take;

	assign kp1 = idx_k + IDX_BITS'(1);

	// The multiplier first forms rows(i) * cols(j) once per cell, then
	// multiplies that by the split dimension at each k.
	assign mul_op  = ctl.ld_pij ? PIJ_BITS'(a_q) : pij_q;
	assign mul_out = PROD_BITS'(mul_op) * PROD_BITS'(dim_rd_q);

	assign prod_w = SAT_BITS'(prod_q);
	assign cmax_w = SAT_BITS'({COST_BITS{1'b1}});
	assign psat   = (prod_w > cmax_w) ? {COST_BITS{1'b1}} : COST_BITS'(prod_w);

	// Diagonal entries of the cost table are zero and are never stored.
	always_comb begin
		if (ctl.acc_en) begin
			add_a = lr_q;
			add_b = psat;
		end else begin
			add_a = zl_q ? '0 : cl_q;
			add_b = zr_q ? '0 : cr_q;
		end
	end

	assign sum_w   = {1'b0, add_a} + {1'b0, add_b};
	assign add_sat = sum_w[COST_BITS] ? {COST_BITS{1'b1}} : sum_w[COST_BITS-1:0];
	assign take    = ctl.first_k || (add_sat < best_q);

	always_ff @(posedge clk) begin
		if (ctl.dim_we) begin
			dim_mem[dim_addr] <= dim_wdata;
		end
		if (ctl.dim_re) begin
			dim_rd_q <= dim_mem[dim_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cost_we) begin
			cost_mem[{idx_i, idx_j}] <= best_q;
		end
		if (ctl.cost_re) begin
			cl_q <= cost_mem[{idx_i, idx_k}];
			cr_q <= cost_mem[{kp1, idx_j}];
			zl_q <= (idx_k == idx_i);
			zr_q <= (kp1 == idx_j);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_a) begin
			a_q <= dim_rd_q;
		end
		if (ctl.ld_pij) begin
			pij_q <= PIJ_BITS'(mul_out);
		end
		if (ctl.mul_en) begin
			prod_q <= mul_out;
			lr_q   <= add_sat;
		end
		if (ctl.acc_en && take) begin
			best_q  <= add_sat;
			bestk_q <= idx_k;
		end
	end

	assign best_cost  = best_q;
	assign best_split = bestk_q;

endmodule

/* rtl/mcodp_ctrl.sv */
// Sequencer of the matrix chain order block: input handshake, dimension
// count, interval and split counters, and the result register.
// Depends on mcodp_pkg for states, status codes and the control word.
module mcodp_ctrl #(
	parameter int MAX_DIMS  = 8,
	parameter int DIM_BITS  = 12,
	parameter int COST_BITS = 48,
	parameter int IDX_BITS  = $clog2(MAX_DIMS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               dim_valid,
	output logic                               dim_stall,
	input  logic [mcodp_pkg::DIM_IN_BITS-1:0]  dimension,
	input  logic                               last,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [mcodp_pkg::COST_OUT_BITS-1:0] min_cost,
	output logic [mcodp_pkg::IDX_OUT_BITS-1:0] root_split,
	output logic [mcodp_pkg::IDX_OUT_BITS-1:0] matrix_count,
	output logic [mcodp_pkg::STATUS_BITS-1:0]  status,
	output mcodp_pkg::step_ctl_t               ctl,
	output logic [IDX_BITS-1:0]                dim_addr,
	output logic [DIM_BITS-1:0]                dim_wdata,
	output logic [IDX_BITS-1:0]                idx_i,
	output logic [IDX_BITS-1:0]                idx_j,
	output logic [IDX_BITS-1:0]                idx_k,
	input  logic [COST_BITS-1:0]               best_cost,
	input  logic [IDX_BITS-1:0]                best_split
);
	import mcodp_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_DIMS + 1);

	st_t                 state_q;
	st_t                 state_d;
	logic [CNT_BITS-1:0] count_q;
	logic                ovf_q;
	logic [IDX_BITS-1:0] n_q;
	logic [IDX_BITS-1:0] i_q;
	logic [IDX_BITS-1:0] j_q;
	logic [IDX_BITS-1:0] k_q;
	logic                res_valid_q;
	logic [COST_OUT_BITS-1:0] min_cost_q;
	logic [IDX_OUT_BITS-1:0]  root_split_q;
	logic [IDX_OUT_BITS-1:0]  matrix_count_q;
	logic [STATUS_BITS-1:0]   status_q;

	logic                out_free;
	logic                in_acc;
	logic                full;
	logic [CNT_BITS-1:0] cnt_new;
	logic                ovf_new;
	logic                cell_last;
	logic                k_end;
	logic                run;

	assign out_free  = !res_valid_q || !res_stall;
	assign dim_stall = (state_q != ST_IDLE) || (last && !out_free);
	assign in_acc    = dim_valid && !dim_stall;
	assign full      = (count_q == CNT_BITS'(MAX_DIMS));
	assign cnt_new   = full ? count_q : count_q + CNT_BITS'(1);
	assign ovf_new   = ovf_q || full;
	assign run       = !ovf_new && (cnt_new > CNT_BITS'(2));
	assign cell_last = (i_q == IDX_BITS'(1)) && (j_q == n_q);
	assign k_end     = ((k_q + IDX_BITS'(1)) == j_q);

	assign dim_wdata = DIM_BITS'(dimension);
	assign idx_i     = i_q;
	assign idx_j     = j_q;
	assign idx_k     = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		dim_addr = count_q[IDX_BITS-1:0];
		case (state_q)
			ST_IDLE: begin
				ctl.dim_we = in_acc && !full;
				if (in_acc && last && run) begin
					state_d = ST_CELL;
				end
			end
			ST_CELL: begin
				ctl.dim_re = 1'b1;
				dim_addr   = i_q - IDX_BITS'(1);
				state_d    = ST_CELL_A;
			end
			ST_CELL_A: begin
				ctl.ld_a   = 1'b1;
				ctl.dim_re = 1'b1;
				dim_addr   = j_q;
				state_d    = ST_CELL_B;
			end
			ST_CELL_B: begin
				ctl.ld_pij = 1'b1;
				state_d    = ST_K_RD;
			end
			ST_K_RD: begin
				ctl.dim_re  = 1'b1;
				ctl.cost_re = 1'b1;
				dim_addr    = k_q;
				state_d     = ST_K_MUL;
			end
			ST_K_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_K_ACC;
			end
			ST_K_ACC: begin
				ctl.acc_en  = 1'b1;
				ctl.first_k = (k_q == i_q);
				state_d     = k_end ? ST_WR : ST_K_RD;
			end
			ST_WR: begin
				ctl.cost_we = 1'b1;
				state_d     = cell_last ? ST_DONE : ST_CELL;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Cells run by increasing chain length; within a length, i walks right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (state_q == ST_IDLE && in_acc) begin
				if (last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					if (run) begin
						n_q <= IDX_BITS'(cnt_new - CNT_BITS'(1));
						i_q <= IDX_BITS'(1);
						j_q <= IDX_BITS'(2);
						k_q <= IDX_BITS'(1);
					end
				end else begin
					count_q <= cnt_new;
					ovf_q   <= ovf_new;
				end
			end
			if (state_q == ST_K_ACC && !k_end) begin
				k_q <= k_q + IDX_BITS'(1);
			end
			if (state_q == ST_WR && !cell_last) begin
				if (j_q == n_q) begin
					i_q <= IDX_BITS'(1);
					j_q <= j_q - i_q + IDX_BITS'(2);
					k_q <= IDX_BITS'(1);
				end else begin
					i_q <= i_q + IDX_BITS'(1);
					j_q <= j_q + IDX_BITS'(1);
					k_q <= i_q + IDX_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if ((state_q == ST_IDLE && in_acc && last && !run) ||
			    (state_q == ST_DONE && out_free)) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && last && !run) begin
			min_cost_q   <= '0;
			root_split_q <= '0;
			if (ovf_new) begin
				matrix_count_q <= '0;
				status_q       <= STAT_OVF;
			end else if (cnt_new < CNT_BITS'(2)) begin
				matrix_count_q <= '0;
				status_q       <= STAT_SHORT;
			end else begin
				// A single matrix costs nothing and has no split.
				matrix_count_q <= IDX_OUT_BITS'(1);
				status_q       <= STAT_OK;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			min_cost_q     <= COST_OUT_BITS'(best_cost);
			root_split_q   <= IDX_OUT_BITS'(best_split);
			matrix_count_q <= IDX_OUT_BITS'(n_q);
			status_q       <= (best_cost == {COST_BITS{1'b1}}) ? STAT_SAT : STAT_OK;
		end
	end

	assign res_valid    = res_valid_q;
	assign min_cost     = min_cost_q;
	assign root_split   = root_split_q;
	assign matrix_count = matrix_count_q;
	assign status       = status_q;

endmodule

/* rtl/matrix_chain_order_dp_core.sv */
// Top level of the matrix chain order block: sequencer plus arithmetic unit.
// Depends on mcodp_pkg, mcodp_ctrl and mcodp_unit.
//
// Usage: dimensions enter on the dim channel (dim_valid, dim_stall,
// dimension, last) one word per cycle while dim_stall is low, in chain
// order, rows of the first matrix first. A word with last set closes the
// chain and, for two or more matrices within the store, starts the interval
// program. The result channel (res_valid, res_stall) then gives one word:
// min_cost, root_split, matrix_count and status. Non-final words are taken
// one per cycle. Over-long, short and single-matrix chains are answered in
// the cycle after their final word is taken. Otherwise the program visits
// n(n-1)/2 cells (ST_CELL, ST_CELL_A, ST_CELL_B, ST_WR) plus (n^3-n)/6
// split steps (ST_K_RD, ST_K_MUL, ST_K_ACC) for n matrices, as set by the
// shared multiplier, saturating adder and registered cost memory reads.
// dim_stall is high while a chain is being solved, and also for a final word
// while an earlier result is still held. A stalled result holds steady.
// Reset clears the dimension count, overflow flag, sequencer and result
// valid; the stores need no clearing since only freshly written entries are
// read.
module matrix_chain_order_dp_core #(
	parameter int MAX_DIMS  = 8,
	parameter int DIM_BITS  = 12,
	parameter int COST_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                dim_valid,
	output logic                                dim_stall,
	input  logic [mcodp_pkg::DIM_IN_BITS-1:0]   dimension,
	input  logic                                last,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [mcodp_pkg::COST_OUT_BITS-1:0] min_cost,
	output logic [mcodp_pkg::IDX_OUT_BITS-1:0]  root_split,
	output logic [mcodp_pkg::IDX_OUT_BITS-1:0]  matrix_count,
	output logic [mcodp_pkg::STATUS_BITS-1:0]   status
);
	import mcodp_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_DIMS);

	step_ctl_t            ctl;
	logic [IDX_BITS-1:0]  dim_addr;
	logic [DIM_BITS-1:0]  dim_wdata;
	logic [IDX_BITS-1:0]  idx_i;
	logic [IDX_BITS-1:0]  idx_j;
	logic [IDX_BITS-1:0]  idx_k;
	logic [COST_BITS-1:0] best_cost;
	logic [IDX_BITS-1:0]  best_split;

	mcodp_ctrl #(
		.MAX_DIMS  (MAX_DIMS),
		.DIM_BITS  (DIM_BITS),
		.COST_BITS (COST_BITS),
		.IDX_BITS  (IDX_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.dim_valid    (dim_valid),
		.dim_stall    (dim_stall),
		.dimension    (dimension),
		.last         (last),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.min_cost     (min_cost),
		.root_split   (root_split),
		.matrix_count (matrix_count),
		.status       (status),
		.ctl          (ctl),
		.dim_addr     (dim_addr),
		.dim_wdata    (dim_wdata),
		.idx_i        (idx_i),
		.idx_j        (idx_j),
		.idx_k        (idx_k),
		.best_cost    (best_cost),
		.best_split   (best_split)
	);

	mcodp_unit #(
		.MAX_DIMS  (MAX_DIMS),
		.DIM_BITS  (DIM_BITS),
		.COST_BITS (COST_BITS),
		.IDX_BITS  (IDX_BITS)
	) u_unit (
		.clk        (clk),
		.ctl        (ctl),
		.dim_addr   (dim_addr),
		.dim_wdata  (dim_wdata),
		.idx_i      (idx_i),
		.idx_j      (idx_j),
		.idx_k      (idx_k),
		.best_cost  (best_cost),
		.best_split (best_split)
	);

endmodule

/* rtl/mcodp_checker.sv */
// Port-level checks for the matrix chain order block, bound to the top level.
// Depends on mcodp_pkg for field widths and status codes.
module mcodp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                dim_valid,
	input logic                                dim_stall,
	input logic [mcodp_pkg::DIM_IN_BITS-1:0]   dimension,
	input logic                                last,
	input logic                                res_valid,
	input logic                                res_stall,
	input logic [mcodp_pkg::COST_OUT_BITS-1:0] min_cost,
	input logic [mcodp_pkg::IDX_OUT_BITS-1:0]  root_split,
	input logic [mcodp_pkg::IDX_OUT_BITS-1:0]  matrix_count,
	input logic [mcodp_pkg::STATUS_BITS-1:0]   status
);
	import mcodp_pkg::*;

	// A held result word must not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(min_cost) &&
		$stable(root_split) && $stable(matrix_count) && $stable(status))
		else $error("result word changed while stalled");

	// Rejected chains carry an all-zero payload.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STAT_OVF || status == STAT_SHORT) |->
		min_cost == '0 && root_split == '0 && matrix_count == '0)
		else $error("error result with nonzero payload");

	// A solved chain of several matrices splits strictly inside it.
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STAT_OK || status == STAT_SAT) &&
		matrix_count > 6'd1 |->
		root_split != '0 && root_split < matrix_count)
		else $error("top-level split outside the chain");

	// A single matrix has no cost and no split; a solved chain is never empty.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STAT_OK || status == STAT_SAT) |->
		matrix_count != '0 &&
		(matrix_count != 6'd1 || (min_cost == '0 && root_split == '0)))
		else $error("inconsistent single-matrix result");

endmodule

bind matrix_chain_order_dp_core mcodp_checker u_mcodp_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for matrix_chain_order_dp_core: sends dimension chains
// and checks each answer against a built-in interval-program predictor.
// Depends on mcodp_pkg and the matrix_chain_order_dp_core RTL.
`timescale 1ns / 1ps

module tb_top;
	import mcodp_pkg::*;

	localparam int MAX_DIMS = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 1500;
	localparam int TAIL_CYCLES = 300;
	localparam logic [COST_OUT_BITS-1:0] COST_LIMIT = '1;

	typedef logic [DIM_IN_BITS-1:0] dim_t;
	typedef logic [COST_OUT_BITS-1:0] cost_t;

	typedef struct packed {
		cost_t                   cost;
		logic [IDX_OUT_BITS-1:0] split;
		logic [IDX_OUT_BITS-1:0] count;
		logic [STATUS_BITS-1:0]  stat;
	} chain_answer_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     dim_valid = 1'b0;
	logic                     dim_stall;
	dim_t                     dimension = '0;
	logic                     last = 1'b0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	cost_t                    min_cost;
	logic [IDX_OUT_BITS-1:0]  root_split;
	logic [IDX_OUT_BITS-1:0]  matrix_count;
	logic [STATUS_BITS-1:0]   status;

	// Chain being collected on the predictor side.
	dim_t          held_dims[MAX_DIMS];
	int unsigned   held_count = 0;
	bit            chain_overflow = 1'b0;
	chain_answer_t pending_answers[$];
	dim_t          next_chain[$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	bit  hold_request = 1'b0;
	int  rx_hold_left = 0;
	int  rx_phase_left = 0;
	int  rx_stall_pct = 0;

	matrix_chain_order_dp_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.dim_valid    (dim_valid),
		.dim_stall    (dim_stall),
		.dimension    (dimension),
		.last         (last),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.min_cost     (min_cost),
		.root_split   (root_split),
		.matrix_count (matrix_count),
		.status       (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL matrix_chain_order_dp_core");
			$finish;
		end
	end

	function automatic cost_t sat_sum(cost_t a, cost_t b);
		logic [COST_OUT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_OUT_BITS] ? COST_LIMIT : s[COST_OUT_BITS-1:0];
	endfunction

	function automatic cost_t sat_mul3(dim_t a, dim_t b, dim_t c);
		logic [63:0] p;
		p = 64'(a) * 64'(b) * 64'(c);
		return (p > 64'(COST_LIMIT)) ? COST_LIMIT : p[COST_OUT_BITS-1:0];
	endfunction

	// Cheapest parenthesization of the held chain, smallest split on ties.
	function automatic chain_answer_t solve_chain();
		cost_t         best[MAX_DIMS][MAX_DIMS];
		int            split_at[MAX_DIMS][MAX_DIMS];
		int            n, span, i, j, k;
		cost_t         q;
		chain_answer_t ans;
		n = held_count - 1;
		for (i = 1; i <= n; i++)
			best[i][i] = '0;
		for (span = 2; span <= n; span++) begin
			for (i = 1; i + span - 1 <= n; i++) begin
				j = i + span - 1;
				for (k = i; k < j; k++) begin
					q = sat_sum(sat_sum(best[i][k], best[k+1][j]),
						sat_mul3(held_dims[i-1], held_dims[k], held_dims[j]));
					if (k == i || q < best[i][j]) begin
						best[i][j] = q;
						split_at[i][j] = k;
					end
				end
			end
		end
		ans.cost = best[1][n];
		ans.split = (n > 1) ? IDX_OUT_BITS'(split_at[1][n]) : '0;
		ans.count = IDX_OUT_BITS'(n);
		ans.stat = (best[1][n] == COST_LIMIT) ? STAT_SAT : STAT_OK;
		return ans;
	endfunction

	function automatic void absorb_word(dim_t d, logic l);
		chain_answer_t ans;
		if (held_count < MAX_DIMS) begin
			held_dims[held_count] = d;
			held_count++;
		end else begin
			chain_overflow = 1'b1;
		end
		if (l) begin
			if (chain_overflow)
				ans = '{cost: '0, split: '0, count: '0, stat: STAT_OVF};
			else if (held_count < 2)
				ans = '{cost: '0, split: '0, count: '0, stat: STAT_SHORT};
			else
				ans = solve_chain();
			pending_answers.push_back(ans);
			held_count = 0;
			chain_overflow = 1'b0;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the word
	// was taken, with valid still high.
	task automatic send_word(input dim_t d, input logic l);
		if (burst_left == 0) begin
			dim_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		dim_valid <= 1'b1;
		dimension <= d;
		last <= l;
		do @(posedge clk); while (dim_stall);
		absorb_word(d, l);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_chain(input dim_t dims[$]);
		foreach (dims[i])
			send_word(dims[i], i == dims.size() - 1);
	endtask

	task automatic wait_drained();
		dim_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending_answers.size() != 0);
	endtask

	function automatic dim_t pick_dimension(int mode);
		case (mode)
			0: return dim_t'($urandom_range(1, 16));
			1: return ($urandom_range(0, 1) == 1) ? dim_t'(4095) : dim_t'(1);
			2: return ($urandom_range(0, 19) == 0) ? dim_t'(0)
				: dim_t'($urandom_range(1, 4095));
			default: return dim_t'($urandom_range(1, 4095));
		endcase
	endfunction

	// Mostly solvable chains of 2 to 8 dimensions; a few single-word and
	// over-long chains mixed in.
	function automatic void make_random_chain();
		int r, len, mode;
		r = $urandom_range(0, 99);
		mode = $urandom_range(0, 4);
		if (r < 6)
			len = 1;
		else if (r < 14)
			len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 4);
		else if (r < 32)
			len = MAX_DIMS;
		else
			len = $urandom_range(2, MAX_DIMS - 1);
		next_chain.delete();
		repeat (len) next_chain.push_back(pick_dimension(mode));
	endfunction

	task automatic test_directed_chains();
		dim_t q[$];
		// Textbook chain of six matrices.
		q = {dim_t'(30), dim_t'(35), dim_t'(15), dim_t'(5), dim_t'(10), dim_t'(20),
			dim_t'(25)};
		send_chain(q);
		// One dimension only: no matrix at all.
		q = {dim_t'(4095)};
		send_chain(q);
		// Single matrix, with a zero dimension.
		q = {dim_t'(4095), dim_t'(0)};
		send_chain(q);
		// Equal dimensions make every split cost the same.
		q = {dim_t'(10), dim_t'(10), dim_t'(10), dim_t'(10)};
		send_chain(q);
		// One word past the store: dropped and flagged.
		q.delete();
		repeat (MAX_DIMS + 1) q.push_back(dim_t'(4095));
		send_chain(q);
		wait_drained();
	endtask

	task automatic test_random_chains(input int word_budget);
		int sent;
		sent = 0;
		while (sent < word_budget) begin
			make_random_chain();
			send_chain(next_chain);
			sent += next_chain.size();
			if ($urandom_range(0, 15) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// Result side holds off while full-length chains keep coming, so the
	// block holds a result and then stalls the next final word.
	task automatic test_result_backpressure();
		dim_t q[$];
		hold_request = 1'b1;
		repeat (4) begin
			q.delete();
			repeat (MAX_DIMS) q.push_back(dim_t'($urandom_range(1, 4095)));
			send_chain(q);
		end
		wait_drained();
	endtask

	// Receiver: phases of differing stall density, plus a long hold on request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (rx_phase_left == 0) begin
				rx_phase_left = $urandom_range(10, 80);
				case ($urandom_range(0, 3))
					0: rx_stall_pct = 0;
					1: rx_stall_pct = 25;
					2: rx_stall_pct = 60;
					default: rx_stall_pct = 90;
				endcase
			end
			rx_phase_left--;
			res_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		chain_answer_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result word: min_cost %0d status %0d", min_cost, status);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (min_cost !== want.cost) begin
					$error("min_cost expected %0d got %0d", want.cost, min_cost);
					error_count++;
				end
				if (root_split !== want.split) begin
					$error("root_split expected %0d got %0d", want.split, root_split);
					error_count++;
				end
				if (matrix_count !== want.count) begin
					$error("matrix_count expected %0d got %0d", want.count, matrix_count);
					error_count++;
				end
				if (status !== want.stat) begin
					$error("status expected %0d got %0d", want.stat, status);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_chains();
		test_result_backpressure();
		test_random_chains(400);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS matrix_chain_order_dp_core");
		end else begin
			$display("FAIL matrix_chain_order_dp_core");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/mcodp_pkg.sv
rtl/mcodp_unit.sv
rtl/mcodp_ctrl.sv
rtl/matrix_chain_order_dp_core.sv
rtl/mcodp_checker.sv
bench/tb_top.sv
